[hdl/fng_pkg.sv]
// Shared types, register indexes and constants for the filtered noise generator.
// No dependencies; compile first.
package fng_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned SAMPLE_W    = 8;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Configuration register indexes
  localparam cfg_index_t REG_FILTER_WEIGHT = 3'd0;
  localparam cfg_index_t REG_NORM_DIVISOR  = 3'd1;
  localparam cfg_index_t REG_DC_OFFSET     = 3'd2;
  localparam cfg_index_t REG_SINE_MIX      = 3'd3;
  localparam cfg_index_t REG_SINE_PHASE    = 3'd4;
  localparam cfg_index_t REG_SEED          = 3'd5;

  // Reset values
  localparam logic [7:0]  RST_FILTER_WEIGHT = 8'd32;
  localparam logic [7:0]  RST_NORM_DIVISOR  = 8'd79;
  localparam logic [7:0]  RST_DC_OFFSET     = 8'd9;
  localparam logic [7:0]  RST_SINE_PHASE    = 8'h1B;
  localparam logic [7:0]  RST_SEED          = 8'd4;
  localparam logic [15:0] ACC_MID           = 16'h8000;

  // Noise byte step constants
  localparam logic [7:0] NOISE_ADD = 8'hBB;
  localparam logic [7:0] NOISE_XOR = 8'h7F;

  localparam logic [7:0] SINE_QUARTER [64] = '{
    8'h81, 8'h84, 8'h87, 8'h8A, 8'h8E, 8'h91, 8'h94, 8'h97,
    8'h9A, 8'h9D, 8'hA0, 8'hA3, 8'hA6, 8'hA9, 8'hAC, 8'hAF,
    8'hB2, 8'hB5, 8'hB8, 8'hBA, 8'hBD, 8'hC0, 8'hC3, 8'hC5,
    8'hC8, 8'hCA, 8'hCD, 8'hCF, 8'hD2, 8'hD4, 8'hD6, 8'hD9,
    8'hDB, 8'hDD, 8'hDF, 8'hE1, 8'hE3, 8'hE5, 8'hE7, 8'hE9,
    8'hEB, 8'hEC, 8'hEE, 8'hEF, 8'hF1, 8'hF2, 8'hF4, 8'hF5,
    8'hF6, 8'hF7, 8'hF8, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFC,
    8'hFD, 8'hFE, 8'hFE, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF
  };

  // Full-period sine rebuilt from the quarter table by mirroring and inverting
  function automatic logic [7:0] full_sine(input logic [7:0] j);
    logic [5:0] idx;
    logic [7:0] q;
    idx = j[6] ? ~j[5:0] : j[5:0];
    q   = SINE_QUARTER[idx];
    return j[7] ? (8'hFF - q) : q;
  endfunction

endpackage

[hdl/fng_if.sv]
// Handshake channel interfaces of the filtered noise generator.
// Depends on fng_pkg.
interface fng_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface fng_out_if import fng_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface fng_cfg_if import fng_pkg::*;;
  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/filtered_noise_generator.sv]
// Filtered noise generator top level: sequencer, shared multiplier, serial divider.
// Depends on fng_pkg and the channel interfaces in fng_if.sv.
//
// Each input transaction (one restart bit) yields one signed 8-bit noise sample.
// A pseudo-random byte is shaped by a square curve, optionally blended 12:4
// with a sine, smoothed by a one-pole lowpass (weight filter_weight/256),
// divided by norm_divisor, stripped of its DC part (0x8000/norm_divisor),
// offset by dc_offset and saturated to -128..127. A new transaction is
// accepted only once the previous sample has entered the output register.
// Each item runs through the square, the two filter products, the restoring
// divider, which retires one quotient bit per cycle and runs two 16-bit
// passes (filter accumulator, then DC term), and the output step; the square,
// the feedback product and the input product share one 16x9 multiplier.
// A finished sample waits in the output register while the next
// transaction is accepted; the sequencer holds in its last step if that
// register is still full. Configuration writes are taken only while the
// sequencer is idle (ready low otherwise); unknown indexes are dropped.
// A divisor of zero acts as one; a weight of zero freezes the accumulator.
module filtered_noise_generator import fng_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  fng_in_if.sink    in_ch,
  fng_out_if.source out_ch,
  fng_cfg_if.sink   cfg
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_MUL0 = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_DIV0 = 3'd4;
  localparam logic [2:0] S_DIV1 = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state;

  // Configuration registers
  logic [7:0] filter_weight;
  logic [7:0] norm_divisor;
  logic [7:0] dc_offset;
  logic       sine_mix;
  logic [7:0] sine_phase;
  logic [7:0] seed;

  // Generator state
  logic [7:0]  noise_byte;
  logic [15:0] filter_acc;
  logic [7:0]  phase_count;

  // Datapath registers
  logic [24:0] prod;
  logic [7:0]  shaped;
  logic [15:0] div_q;
  logic [7:0]  div_rem;
  logic [3:0]  div_cnt;
  logic [15:0] quot_acc;
  logic        out_valid;
  sample_t     sample;

  logic in_fire;
  logic cfg_fire;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg.valid && cfg.ready;

  assign in_ch.ready   = (state == S_IDLE);
  assign cfg.ready     = (state == S_IDLE);
  assign out_ch.valid  = out_valid;
  assign out_ch.sample = sample;

  // ---------------- shared multiplier ----------------
  logic [7:0]  sq_operand;
  logic [15:0] mul_a;
  logic [8:0]  mul_b;
  logic [24:0] mul_out;

  // Square operand is the distance from the nearer rail, always below 0x80
  assign sq_operand = noise_byte[7] ? (8'hFF - noise_byte) : noise_byte;

  always_comb begin
    unique case (state)
      S_SQ: begin
        mul_a = {8'h00, sq_operand};
        mul_b = {1'b0, sq_operand};
      end
      S_MUL0: begin
        mul_a = filter_acc;
        mul_b = 9'd256 - {1'b0, filter_weight};
      end
      default: begin
        mul_a = {shaped, 8'h00};
        mul_b = {1'b0, filter_weight};
      end
    endcase
  end

  assign mul_out = 25'({9'd0, mul_a} * {16'd0, mul_b});

  // ---------------- shaping and sine blend ----------------
  logic [7:0]  shape_val;
  logic [7:0]  sine_val;
  logic [11:0] mix_sum;
  logic [7:0]  shaped_next;

  assign shape_val = noise_byte[7] ? (8'hFF - prod[14:7]) : prod[14:7];
  assign sine_val  = full_sine(8'(phase_count + sine_phase));
  assign mix_sum   = {2'b00, sine_val, 2'b00} + {1'b0, shape_val, 3'b000}
                   + {2'b00, shape_val, 2'b00};
  assign shaped_next = sine_mix ? mix_sum[11:4] : shape_val;

  // ---------------- lowpass update ----------------
  logic [25:0] filt_sum;
  logic [15:0] acc_next;

  assign filt_sum = {1'b0, prod} + {1'b0, mul_out};
  assign acc_next = filt_sum[23:8];

  // ---------------- serial divider step ----------------
  logic [7:0] d_eff;
  logic [8:0] trial;
  logic [8:0] trial_diff;
  logic       trial_ge;
  logic [7:0] rem_next;
  logic [15:0] q_next;

  assign d_eff      = (norm_divisor == 8'd0) ? 8'd1 : norm_divisor;
  assign trial      = {div_rem, div_q[15]};
  assign trial_ge   = (trial >= {1'b0, d_eff});
  assign trial_diff = trial - {1'b0, d_eff};
  assign rem_next   = trial_ge ? trial_diff[7:0] : trial[7:0];
  assign q_next     = {div_q[14:0], trial_ge};

  // ---------------- output assembly ----------------
  logic signed [17:0] out_sum;
  sample_t            sat_val;

  assign out_sum = $signed({2'b00, quot_acc}) - $signed({2'b00, div_q})
                 + 18'(signed'(dc_offset));

  always_comb begin
    if (out_sum < -18'sd128) begin
      sat_val = -8'sd128;
    end else if (out_sum > 18'sd127) begin
      sat_val = 8'sd127;
    end else begin
      sat_val = out_sum[7:0];
    end
  end

  logic [7:0] noise_step;
  assign noise_step = (8'({7'd0, noise_byte[7]}) + {noise_byte[6:0], 1'b0} + NOISE_ADD)
                    ^ NOISE_XOR;

  logic out_free;
  assign out_free = !out_valid || out_ch.ready;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_weight <= RST_FILTER_WEIGHT;
      norm_divisor  <= RST_NORM_DIVISOR;
      dc_offset     <= RST_DC_OFFSET;
      sine_mix      <= 1'b0;
      sine_phase    <= RST_SINE_PHASE;
      seed          <= RST_SEED;
    end else if (cfg_fire) begin
      unique case (cfg.index)
        REG_FILTER_WEIGHT: filter_weight <= cfg.data;
        REG_NORM_DIVISOR:  norm_divisor  <= cfg.data;
        REG_DC_OFFSET:     dc_offset     <= cfg.data;
        REG_SINE_MIX:      sine_mix      <= cfg.data[0];
        REG_SINE_PHASE:    sine_phase    <= cfg.data;
        REG_SEED:          seed          <= cfg.data;
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      noise_byte  <= RST_SEED;
      filter_acc  <= ACC_MID;
      phase_count <= 8'd0;
      out_valid   <= 1'b0;
      div_cnt     <= 4'd0;
    end else begin
      // The output step reloads the register itself when the old sample leaves
      if (out_valid && out_ch.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            // Restart reloads the generator before this sample is made
            if (in_ch.restart) begin
              noise_byte  <= seed;
              filter_acc  <= ACC_MID;
              phase_count <= 8'd0;
            end
            state <= S_SQ;
          end
        end
        S_SQ: begin
          prod  <= mul_out;
          state <= S_MUL0;
        end
        S_MUL0: begin
          shaped <= shaped_next;
          prod   <= mul_out;
          state  <= S_MUL1;
        end
        S_MUL1: begin
          filter_acc <= acc_next;
          div_q      <= acc_next;
          div_rem    <= 8'd0;
          div_cnt    <= 4'd0;
          state      <= S_DIV0;
        end
        S_DIV0: begin
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'd15) begin
            // First quotient done; load the DC term as next dividend
            quot_acc <= q_next;
            div_q    <= ACC_MID;
            div_rem  <= 8'd0;
            state    <= S_DIV1;
          end else begin
            div_q   <= q_next;
            div_rem <= rem_next;
          end
        end
        S_DIV1: begin
          div_cnt <= div_cnt + 4'd1;
          div_q   <= q_next;
          div_rem <= rem_next;
          if (div_cnt == 4'd15) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold until the output register can take the sample
          if (out_free) begin
            sample      <= sat_val;
            out_valid   <= 1'b1;
            noise_byte  <= noise_step;
            phase_count <= phase_count + 8'd1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == S_SQ)
    else $error("accepted transaction did not start the sequencer");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV0 || state == S_DIV1) |-> div_rem < d_eff)
    else $error("divider remainder not below divisor");

  a_restart_seed: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_ch.restart |=> noise_byte == $past(seed) && filter_acc == ACC_MID)
    else $error("restart did not reload the generator");

  a_valid_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("sample shown outside the output step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(sample))
    else $error("pending sample overwritten");

endmodule

[test/tb_top.sv]
// Self-checking testbench for filtered_noise_generator: directed and random noise ticks,
// configuration sweeps, an in-bench sample predictor and a result scoreboard.
// Depends on fng_pkg and the channel interfaces in fng_if.sv.
module tb_top import fng_pkg::*;;

  // Register indexes the block does not decode; writes to them must be dropped.
  localparam cfg_index_t REG_UNUSED_6 = 3'd6;
  localparam cfg_index_t REG_UNUSED_7 = 3'd7;

  localparam int TOTAL_ITEMS     = 950;   // directed plus random ticks
  localparam int SETTLE_CYCLES   = 40;    // one full item latency and then some
  localparam int WATCHDOG_LIMIT  = 1500;  // cycles without any transaction

  localparam logic [15:0] ACC_RESTART = 16'h8000;
  localparam logic [7:0]  STEP_ADD    = 8'hBB;
  localparam logic [7:0]  STEP_XOR    = 8'h7F;

  // Quarter-wave sine, first quadrant; the rest is rebuilt by mirroring.
  localparam logic [7:0] QSINE [64] = '{
    8'h81, 8'h84, 8'h87, 8'h8A, 8'h8E, 8'h91, 8'h94, 8'h97,
    8'h9A, 8'h9D, 8'hA0, 8'hA3, 8'hA6, 8'hA9, 8'hAC, 8'hAF,
    8'hB2, 8'hB5, 8'hB8, 8'hBA, 8'hBD, 8'hC0, 8'hC3, 8'hC5,
    8'hC8, 8'hCA, 8'hCD, 8'hCF, 8'hD2, 8'hD4, 8'hD6, 8'hD9,
    8'hDB, 8'hDD, 8'hDF, 8'hE1, 8'hE3, 8'hE5, 8'hE7, 8'hE9,
    8'hEB, 8'hEC, 8'hEE, 8'hEF, 8'hF1, 8'hF2, 8'hF4, 8'hF5,
    8'hF6, 8'hF7, 8'hF8, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFC,
    8'hFD, 8'hFE, 8'hFE, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF
  };

  logic clk = 1'b0;
  logic rst;

  fng_in_if  in_ch ();
  fng_out_if out_ch ();
  fng_cfg_if cfg_ch ();

  filtered_noise_generator dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the registers and of the generator.
  // ---------------------------------------------------------------------------
  logic [7:0]        reg_weight;
  logic [7:0]        reg_divisor;
  logic signed [7:0] reg_offset;
  logic              reg_mix;
  logic [7:0]        reg_phase;
  logic [7:0]        reg_seed;

  logic [7:0]  noise_q;
  logic [15:0] acc_q;
  logic [7:0]  phase_q;

  sample_t expected_samples [$];
  sample_t next_sample;

  int items_sent;
  int restarts_sent;
  int samples_checked;
  int cfg_writes;
  int mismatches;

  // Sender bookkeeping
  int burst_left;
  bit feed_active;
  bit steady_feed;

  // Square curve, symmetric about mid-scale.
  function automatic int unsigned shape_curve(input logic [7:0] r);
    int unsigned t;
    if (r < 8'h80) begin
      t = r;
      return (t * t) >> 7;
    end
    t = 8'hFF - r;
    return 255 - ((t * t) >> 7);
  endfunction

  // Full sine period from the quarter table: mirror in odd quadrants,
  // invert in the lower half.
  function automatic int unsigned sine_at(input logic [7:0] j);
    case (j[7:6])
      2'd0:    return QSINE[j[5:0]];
      2'd1:    return QSINE[6'd63 - j[5:0]];
      2'd2:    return 255 - QSINE[j[5:0]];
      default: return 255 - QSINE[6'd63 - j[5:0]];
    endcase
  endfunction

  task automatic reset_predictor();
    reg_weight  = 8'd32;
    reg_divisor = 8'd79;
    reg_offset  = 8'sd9;
    reg_mix     = 1'b0;
    reg_phase   = 8'd27;
    reg_seed    = 8'd4;
    noise_q     = 8'd4;
    acc_q       = ACC_RESTART;
    phase_q     = 8'd0;
  endtask

  task automatic apply_reg(input cfg_index_t idx, input cfg_data_t val);
    case (idx)
      REG_FILTER_WEIGHT: reg_weight  = val;
      REG_NORM_DIVISOR:  reg_divisor = val;
      REG_DC_OFFSET:     reg_offset  = val;
      REG_SINE_MIX:      reg_mix     = val[0];
      REG_SINE_PHASE:    reg_phase   = val;
      REG_SEED:          reg_seed    = val;
      default: ;  // undecoded index: no effect
    endcase
  endtask

  // Advance the generator by one tick and return the sample it produces.
  function automatic sample_t predict_sample(input logic restart);
    int unsigned s;
    int unsigned w;
    int unsigned d;
    int unsigned acc_next;
    int          v;
    logic [7:0]  j;
    if (restart) begin
      noise_q = reg_seed;
      acc_q   = ACC_RESTART;
      phase_q = 8'd0;
    end
    s = shape_curve(noise_q);
    if (reg_mix) begin
      j = phase_q + reg_phase;
      s = (4 * sine_at(j) + 12 * s) >> 4;
    end
    // One-pole lowpass; weight zero keeps the accumulator as it is.
    w        = reg_weight;
    acc_next = (acc_q * (256 - w) + (s << 8) * w) >> 8;
    acc_q    = 16'(acc_next);
    // A zero divisor acts as one.
    d = (reg_divisor == 8'd0) ? 1 : reg_divisor;
    v = int'(acc_q / d) - int'(32'h8000 / d) + int'(reg_offset);
    if (v < -128) v = -128;
    if (v > 127)  v = 127;
    noise_q = ((noise_q >> 7) + (noise_q << 1) + STEP_ADD) ^ STEP_XOR;
    phase_q = phase_q + 8'd1;
    return sample_t'(v);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: apply register writes, predict on each accepted tick, and
  // check each accepted sample against the oldest prediction. Handshakes are
  // sampled at the edge, so values read here are the pre-edge ones.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready)
        apply_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready)
        expected_samples.push_back(predict_sample(in_ch.restart));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected sample %0d with nothing pending",
                                    out_ch.sample));
        end else begin
          next_sample = expected_samples.pop_front();
          if (out_ch.sample !== next_sample)
            report_mismatch($sformatf("sample %0d: got %0d, predicted %0d",
                                      samples_checked, out_ch.sample, next_sample));
          samples_checked++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure. Switch between randomly picked modes:
  // always ready, coin-flip ready, ready with occasional long stalls, and a
  // fixed one-in-four pattern. Drive ready only here.
  // ---------------------------------------------------------------------------
  int rx_mode       = 0;
  int rx_mode_left  = 100;
  int rx_stall_left = 0;
  int rx_tick       = 0;

  always @(posedge clk) begin
    rx_tick++;
    if (rx_stall_left != 0) begin
      rx_stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: begin
          out_ch.ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_stall_left = $urandom_range(1, 30);
        end
        default: out_ch.ready <= (rx_tick % 4 == 0);
      endcase
    end
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(50, 400);
    end else begin
      rx_mode_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if no transaction moves on any channel for too long.
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TIMEOUT: no transaction for %0d cycles, %0d samples pending",
               idle_cycles, expected_samples.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one tick. Bursts of random length, random gaps in between; valid
  // stays high across back-to-back transactions so it never drops and rises
  // within one time step.
  task automatic send_tick(input logic restart);
    int gap;
    if (burst_left == 0) begin
      gap = steady_feed ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        if (feed_active) begin
          in_ch.valid <= 1'b0;
          feed_active = 1'b0;
        end
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    feed_active = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    burst_left--;
    items_sent++;
    if (restart) restarts_sent++;
  endtask

  // Drop valid, then hold until every predicted sample has been checked and
  // the sequencer has had time to go idle.
  task automatic wait_quiet();
    if (feed_active) begin
      in_ch.valid <= 1'b0;
      feed_active = 1'b0;
    end
    burst_left = 0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; valid drops for a cycle before the next write.
  task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Run from reset values without any write, then one restart.
  task automatic test_reset_values();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_quiet();
  endtask

  // Zero weight freezes the accumulator; 1 and 255 are the ends of the range.
  task automatic test_filter_weight();
    cfg_data_t weights [3] = '{8'd0, 8'd1, 8'd255};
    foreach (weights[k]) begin
      write_reg(REG_FILTER_WEIGHT, weights[k]);
      send_tick(1'b1);
      send_tick(1'b0);
      wait_quiet();
    end
  endtask

  // Zero divisor acts as one; 1 saturates hard, 255 is the largest divisor.
  task automatic test_norm_divisor();
    cfg_data_t divisors [3] = '{8'd0, 8'd1, 8'd255};
    foreach (divisors[k]) begin
      write_reg(REG_NORM_DIVISOR, divisors[k]);
      send_tick(1'b0);
      send_tick(1'b0);
      wait_quiet();
    end
  endtask

  // Offset extremes with a small divisor drive both saturation limits.
  task automatic test_offset_saturation();
    write_reg(REG_NORM_DIVISOR, 8'd1);
    write_reg(REG_DC_OFFSET, 8'h80);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_quiet();
    write_reg(REG_DC_OFFSET, 8'h7F);
    send_tick(1'b0);
    send_tick(1'b0);
    wait_quiet();
  endtask

  // Sine blend at both phase extremes and both seed extremes.
  task automatic test_sine_mix();
    write_reg(REG_NORM_DIVISOR, 8'd64);
    write_reg(REG_DC_OFFSET, 8'h00);
    write_reg(REG_SINE_MIX, 8'h01);
    write_reg(REG_SINE_PHASE, 8'h00);
    write_reg(REG_SEED, 8'h00);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_quiet();
    write_reg(REG_SINE_PHASE, 8'hFF);
    write_reg(REG_SEED, 8'hFF);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_quiet();
  endtask

  // Writes to undecoded indexes must leave every register untouched.
  task automatic test_unknown_index();
    write_reg(REG_UNUSED_6, 8'hFF);
    write_reg(REG_UNUSED_7, 8'h01);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_quiet();
  endtask

  // ---------------------------------------------------------------------------
  // Random phases: fresh settings between phases, rare restarts, and in some
  // phases a pause mid-stream until the output side has drained.
  // ---------------------------------------------------------------------------
  task automatic randomize_config();
    if ($urandom_range(0, 1))
      case ($urandom_range(0, 5))
        0:       write_reg(REG_FILTER_WEIGHT, 8'd1);
        1:       write_reg(REG_FILTER_WEIGHT, 8'd255);
        default: write_reg(REG_FILTER_WEIGHT, 8'($urandom_range(1, 255)));
      endcase
    if ($urandom_range(0, 1))
      case ($urandom_range(0, 5))
        0:       write_reg(REG_NORM_DIVISOR, 8'd1);
        1:       write_reg(REG_NORM_DIVISOR, 8'd255);
        default: write_reg(REG_NORM_DIVISOR, 8'($urandom_range(1, 255)));
      endcase
    if ($urandom_range(0, 1)) write_reg(REG_DC_OFFSET, 8'($urandom));
    if ($urandom_range(0, 1)) write_reg(REG_SINE_MIX, 8'($urandom_range(0, 1)));
    if ($urandom_range(0, 1)) write_reg(REG_SINE_PHASE, 8'($urandom));
    if ($urandom_range(0, 1)) write_reg(REG_SEED, 8'($urandom));
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_UNUSED_6 : REG_UNUSED_7, 8'($urandom));
  endtask

  task automatic test_random_phases();
    int phase;
    int n;
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      randomize_config();
      steady_feed = (phase % 4 == 1);
      n = $urandom_range(50, 100);
      // Stop exactly at the planned item count.
      if (n > TOTAL_ITEMS - items_sent) n = TOTAL_ITEMS - items_sent;
      for (int i = 0; i < n; i++) begin
        // Hold the sender until every pending sample has come back.
        if ((phase % 5 == 2) && (i == n / 2)) wait_quiet();
        send_tick($urandom_range(0, 19) == 0);
      end
      steady_feed = 1'b0;
      wait_quiet();
      phase++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst            <= 1'b1;
    in_ch.valid    <= 1'b0;
    in_ch.restart  <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= REG_FILTER_WEIGHT;
    cfg_ch.data    <= '0;
    burst_left     = 0;
    feed_active    = 1'b0;
    steady_feed    = 1'b0;
    reset_predictor();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_filter_weight();
    test_norm_divisor();
    test_offset_saturation();
    test_sine_mix();
    test_unknown_index();
    test_random_phases();

    // Everything was drained by the last phase; give the block one more
    // latency's worth of cycles to show any stray output.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_samples.size() != 0)
      report_mismatch($sformatf("%0d predicted samples never arrived",
                                expected_samples.size()));

    $display("Summary: %0d ticks sent (%0d with restart), %0d samples checked",
             items_sent, restarts_sent, samples_checked);
    $display("Summary: %0d register writes across directed and random settings, %0d errors",
             cfg_writes, mismatches);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
hdl/fng_pkg.sv
hdl/fng_if.sv
hdl/filtered_noise_generator.sv
test/tb_top.sv
